>>> rtl/assert_macros.svh
// assertion helpers, sampled on clk and disabled during rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// pre at one edge implies post at the next
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/mpst_pkg.sv
`default_nettype none

package mpst_pkg;

  localparam int CNT_W = 4;

  localparam logic [7:0] MP_NIL     = 8'hc0;
  localparam logic [7:0] MP_FALSE   = 8'hc2;
  localparam logic [7:0] MP_TRUE    = 8'hc3;
  localparam logic [7:0] MP_FLOAT32 = 8'hca;
  localparam logic [7:0] MP_FLOAT64 = 8'hcb;

  localparam logic [63:0] NEG_FIX_EXT = 64'hFFFF_FFFF_FFFF_FF00;

  typedef enum logic [3:0] {
    EV_NIL      = 4'd0,
    EV_BOOL     = 4'd1,
    EV_UINT     = 4'd2,
    EV_SINT     = 4'd3,
    EV_F32      = 4'd4,
    EV_F64      = 4'd5,
    EV_RAWSTART = 4'd6,
    EV_RAWBYTE  = 4'd7,
    EV_ARRAY    = 4'd8,
    EV_ERROR    = 4'd9
  } ev_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_MAP     = 2'd2,
    ERR_DEPTH   = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    CL_NIL,
    CL_BOOL,
    CL_UINT,
    CL_SINT,
    CL_NUM,
    CL_RAW,
    CL_ARRAY,
    CL_ERR
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    ev_t        ev;
    logic [1:0] lg;
    err_t       err;
  } dec_t;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic             close;
    logic [CNT_W-1:0] cnt;
  } stk_op_t;

endpackage

`default_nettype wire

>>> rtl/msgpack_stream_tokenizer_unit.sv
// an accepted byte is held in the input register, decoded, then registered as a token beat
// throughput: one byte per cycle unless out_ready stalls the result register, set by the
//   single decode stage between the input register and the result register
// multi-byte numbers give one token on their last byte only
// reset: synchronous active-low rst_n clears both stages, the parse phase
//   and the stack level; payload registers are not reset
`default_nettype none
`include "assert_macros.svh"

module msgpack_stream_tokenizer_unit #(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [63:0] out_value,
  output logic [3:0]  out_level,
  output logic        out_object_done,
  output logic [1:0]  out_error_code
);
  import mpst_pkg::*;

  localparam int LW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_NUM,
    PH_RAW
  } ph_t;

  ph_t         phase_r, phase_nxt;
  logic        a_v_r;
  logic [7:0]  a_byte_r;
  logic        a_fire;
  logic [4:0]  bl_r, bl_nxt, bl_dec;
  logic [63:0] acc_r, acc_nxt, acc_sh;
  ev_t         kind_r, kind_nxt;
  logic [1:0]  lg_r, lg_nxt;

  logic        emit;
  ev_t         ev;
  logic [63:0] val;
  logic        done;
  err_t        err;
  logic        clr;
  stk_op_t     sop, sop_g;

  logic          out_v_r;
  ev_t           ev_r;
  logic [63:0]   val_r;
  logic [3:0]    lvl_r;
  logic          done_r;
  err_t          err_r;

  dec_t          dec;
  logic [LW-1:0] stk_level;
  logic          stk_full;
  logic          stk_done;

  mpst_decode u_decode (
    .type_byte (a_byte_r),
    .dec       (dec)
  );

  mpst_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (sop_g),
    .level      (stk_level),
    .full       (stk_full),
    .close_done (stk_done)
  );

  assign a_fire   = a_v_r && (!out_v_r || out_ready);
  assign in_ready = !a_v_r || a_fire;
  assign acc_sh   = {acc_r[55:0], a_byte_r};
  assign bl_dec   = bl_r - 5'((bl_r != 5'd0) ? 1 : 0);

  always_comb begin
    phase_nxt = phase_r;
    bl_nxt    = bl_r;
    acc_nxt   = acc_r;
    kind_nxt  = kind_r;
    lg_nxt    = lg_r;
    emit      = 1'b0;
    ev        = EV_NIL;
    val       = '0;
    done      = 1'b0;
    err       = ERR_NONE;
    clr       = 1'b0;
    sop       = '0;
    unique case (phase_r)
      PH_NUM: begin
        acc_nxt = acc_sh;
        bl_nxt  = bl_dec;
        if (bl_dec == 5'd0) begin
          val = acc_sh;
          if (kind_r == EV_SINT) begin
            case (lg_r)
              2'd0:    val = {{56{acc_sh[7]}}, acc_sh[7:0]};
              2'd1:    val = {{48{acc_sh[15]}}, acc_sh[15:0]};
              2'd2:    val = {{32{acc_sh[31]}}, acc_sh[31:0]};
              default: val = acc_sh;
            endcase
          end
          acc_nxt   = val;
          phase_nxt = PH_TYPE;
          emit      = 1'b1;
          ev        = kind_r;
          sop.close = 1'b1;
          done      = stk_done;
        end
      end
      PH_RAW: begin
        bl_nxt = bl_dec;
        emit   = 1'b1;
        ev     = EV_RAWBYTE;
        val    = {56'd0, a_byte_r};
        if (bl_dec == 5'd0) begin
          phase_nxt = PH_TYPE;
          sop.close = 1'b1;
          done      = stk_done;
        end
      end
      default: begin
        phase_nxt = PH_TYPE;
        case (dec.cls)
          CL_NIL: begin
            emit      = 1'b1;
            ev        = EV_NIL;
            sop.close = 1'b1;
            done      = stk_done;
          end
          CL_BOOL: begin
            emit      = 1'b1;
            ev        = EV_BOOL;
            val       = {63'd0, a_byte_r[0]};
            sop.close = 1'b1;
            done      = stk_done;
          end
          CL_UINT: begin
            emit      = 1'b1;
            ev        = EV_UINT;
            val       = {56'd0, a_byte_r};
            sop.close = 1'b1;
            done      = stk_done;
          end
          CL_SINT: begin
            emit      = 1'b1;
            ev        = EV_SINT;
            val       = NEG_FIX_EXT | {56'd0, a_byte_r};
            sop.close = 1'b1;
            done      = stk_done;
          end
          CL_NUM: begin
            phase_nxt = PH_NUM;
            kind_nxt  = dec.ev;
            lg_nxt    = dec.lg;
            bl_nxt    = 5'd1 << dec.lg;
            acc_nxt   = '0;
          end
          CL_RAW: begin
            emit = 1'b1;
            ev   = EV_RAWSTART;
            val  = {59'd0, a_byte_r[4:0]};
            if (a_byte_r[4:0] == 5'd0) begin
              sop.close = 1'b1;
              done      = stk_done;
            end else begin
              phase_nxt = PH_RAW;
              bl_nxt    = a_byte_r[4:0];
            end
          end
          CL_ARRAY: begin
            if (a_byte_r[3:0] == 4'd0) begin
              emit      = 1'b1;
              ev        = EV_ARRAY;
              sop.close = 1'b1;
              done      = stk_done;
            end else if (stk_full) begin
              clr = 1'b1;
              err = ERR_DEPTH;
            end else begin
              emit     = 1'b1;
              ev       = EV_ARRAY;
              val      = {60'd0, a_byte_r[3:0]};
              sop.push = 1'b1;
              sop.cnt  = a_byte_r[3:0];
            end
          end
          default: begin
            clr = 1'b1;
            err = dec.err;
          end
        endcase
        if (clr) begin
          emit      = 1'b1;
          ev        = EV_ERROR;
          val       = {56'd0, a_byte_r};
          done      = 1'b0;
          phase_nxt = PH_TYPE;
          bl_nxt    = '0;
          acc_nxt   = '0;
          kind_nxt  = EV_NIL;
          lg_nxt    = '0;
          sop       = '0;
          sop.clear = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    sop_g       = sop;
    sop_g.clear = sop.clear && a_fire;
    sop_g.push  = sop.push && a_fire;
    sop_g.close = sop.close && a_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_TYPE;
      bl_r    <= '0;
      acc_r   <= '0;
      kind_r  <= EV_NIL;
      lg_r    <= '0;
    end else begin
      if (in_ready) a_v_r <= in_valid;
      if (a_fire) begin
        out_v_r <= emit;
        phase_r <= phase_nxt;
        bl_r    <= bl_nxt;
        acc_r   <= acc_nxt;
        kind_r  <= kind_nxt;
        lg_r    <= lg_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) a_byte_r <= in_byte;
    if (a_fire && emit) begin
      ev_r   <= ev;
      val_r  <= val;
      lvl_r  <= 4'(stk_level);
      done_r <= done;
      err_r  <= err;
    end
  end

  assign out_valid       = out_v_r;
  assign out_event_res   = ev_r;
  assign out_value       = val_r;
  assign out_level       = lvl_r;
  assign out_object_done = done_r;
  assign out_error_code  = err_r;

  `ASSERT_ALWAYS(a_err_code, !out_v_r || ((ev_r == EV_ERROR) == (err_r != ERR_NONE)), "error code mismatch")
  `ASSERT_NEXT(a_err_restart, a_fire && clr, (phase_r == PH_TYPE) && (stk_level == '0), "no restart after error")
  `ASSERT_ALWAYS(a_err_not_done, !out_v_r || (ev_r != EV_ERROR) || !done_r, "error beat marked done")

endmodule

`default_nettype wire

>>> rtl/mpst_decode.sv
`default_nettype none

module mpst_decode (
  input  logic [7:0]     type_byte,
  output mpst_pkg::dec_t dec
);
  import mpst_pkg::*;

  always_comb begin
    dec.cls = CL_ERR;
    dec.ev  = EV_NIL;
    dec.lg  = 2'd0;
    dec.err = ERR_NONE;
    unique case (type_byte) inside
      [8'h00:8'h7f]: dec.cls = CL_UINT;
      [8'he0:8'hff]: dec.cls = CL_SINT;
      MP_NIL:        dec.cls = CL_NIL;
      MP_FALSE, MP_TRUE: dec.cls = CL_BOOL;
      [8'hcc:8'hcf]: begin
        dec.cls = CL_NUM;
        dec.ev  = EV_UINT;
        dec.lg  = type_byte[1:0];
      end
      [8'hd0:8'hd3]: begin
        dec.cls = CL_NUM;
        dec.ev  = EV_SINT;
        dec.lg  = type_byte[1:0];
      end
      MP_FLOAT32: begin
        dec.cls = CL_NUM;
        dec.ev  = EV_F32;
        dec.lg  = 2'd2;
      end
      MP_FLOAT64: begin
        dec.cls = CL_NUM;
        dec.ev  = EV_F64;
        dec.lg  = 2'd3;
      end
      [8'ha0:8'hbf]: dec.cls = CL_RAW;
      [8'h90:8'h9f]: dec.cls = CL_ARRAY;
      [8'h80:8'h8f]: dec.err = ERR_MAP;
      default:       dec.err = ERR_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/mpst_stack.sv
`default_nettype none
`include "assert_macros.svh"

module mpst_stack #(
  parameter int MAX_DEPTH = 8,
  parameter int LW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mpst_pkg::stk_op_t op,
  output logic [LW-1:0]     level,
  output logic              full,
  output logic              close_done
);
  import mpst_pkg::*;

  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [CNT_W-1:0] cnt_r   [MAX_DEPTH];
  logic [CNT_W-1:0] cnt_nxt [MAX_DEPTH];
  logic [LW-1:0]    lvl_r, lvl_nxt;
  logic [MAX_DEPTH-1:0] gt1;
  logic             found;
  logic [IW-1:0]    top;

  // highest open level that survives a close
  always_comb begin
    found = 1'b0;
    top   = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      gt1[i] = (cnt_r[i] > CNT_W'(1)) && (LW'(i) < lvl_r);
      if (gt1[i]) begin
        found = 1'b1;
        top   = IW'(i);
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    lvl_nxt = lvl_r;
    if (op.clear) begin
      lvl_nxt = '0;
    end else if (op.push) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        if (lvl_r == LW'(i)) cnt_nxt[i] = op.cnt;
      end
      lvl_nxt = lvl_r + LW'(1);
    end else if (op.close) begin
      if (found) begin
        lvl_nxt      = LW'(top) + LW'(1);
        cnt_nxt[top] = cnt_r[top] - CNT_W'(1);
      end else begin
        lvl_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else begin
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  assign level      = lvl_r;
  assign full       = (lvl_r == LW'(MAX_DEPTH));
  assign close_done = !found;

  `ASSERT_ALWAYS(a_lvl_max, lvl_r <= LW'(MAX_DEPTH), "stack level beyond max depth")
  `ASSERT_NEXT(a_close_pop, op.close && !op.push && !op.clear, lvl_r <= $past(lvl_r), "close grew stack")

endmodule

`default_nettype wire
